// File: rtl/multi_stack_shared_store_defines.svh
// Assertion macros shared by the multi-stack store RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef MULTI_STACK_SHARED_STORE_DEFINES_SVH
`define MULTI_STACK_SHARED_STORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Whenever pre holds, post must hold in the same cycle.
`define MSS_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Whenever pre holds, post must hold in the following cycle.
`define MSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// The condition must never hold.
`define MSS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`else

`define MSS_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define MSS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`define MSS_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: rtl/mss_pkg.sv
`timescale 1ns / 1ps

package mss_pkg;

  // Operation carried by an input item.
  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } mss_action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } mss_status_t;

  // Input item.
  typedef struct packed {
    mss_action_t action;
    logic [3:0]  stack_index;
    logic [7:0]  push_data;
  } mss_in_t;

  // Result item.
  typedef struct packed {
    logic [7:0]  pop_data;
    mss_status_t status;
    logic [5:0]  stack_size;
  } mss_out_t;

  // Which stack the base and top read ports look at.
  typedef enum logic [1:0] {
    RD_S,
    RD_S1,
    RD_P
  } mss_rdsel_t;

  // How the reported stack size follows from the captured size.
  typedef enum logic [1:0] {
    SZ_ZERO,
    SZ_SAME,
    SZ_DEC,
    SZ_INC
  } mss_szsel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic        load_item;
    mss_rdsel_t  rd_sel;
    logic        cap_s;
    logic        cap_s1;
    logic        scan_init;
    logic        scan_step;
    logic        left;
    logic        hit;
    logic        pop_read;
    logic        pop_commit;
    logic        push_write;
    logic        respond;
    mss_status_t resp_status;
    mss_szsel_t  resp_size;
    logic        resp_pop;
  } mss_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bad_index;
    logic is_pop;
    logic empty;
    logic room;
    logic p_free;
    logic p_last;
    logic p_zero;
    logic s_last;
    logic s_zero;
    logic shift_busy;
  } mss_sts_t;

endpackage

// File: rtl/multi_stack_shared_store.sv
`timescale 1ns / 1ps
// Several stacks sharing one entry store. An item (push or pop on one stack)
// is taken at a rising edge with start high and busy low; busy then stays
// high until the item is finished. Each item gives one result, shown on
// out_item for a single cycle with out_valid high; the result is a transfer
// that the receiver cannot hold off, and a new start is taken in that cycle.
// A pop from an empty stack, or any item with a stack index out of range, is
// answered from the decide state; a pop with data goes on through a read
// wait, and a push with free room goes straight to the push write. A push
// into a full store is refused once all other stacks have been scanned. A
// push onto a stack that has run into its neighbour repacks the store: it
// scans at most NUM_STACKS - 1 other stacks for room, moves the entries in
// between one slot each, and then writes the push. Repacking moves one entry
// per cycle through the entry store, which has one write port and one
// registered read port, and the scan reads one stack's limits per cycle.
// Reset (rst_n low, synchronous) empties all stacks and splits the store
// evenly among them at once, with no clearing pass; entries hold no defined
// value until written.
module multi_stack_shared_store #(
  parameter int NUM_STACKS  = 13,
  parameter int CAPACITY    = 52,
  parameter int ENTRY_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mss_pkg::mss_in_t  in_item,
  output logic              out_valid,
  output mss_pkg::mss_out_t out_item
);

  mss_pkg::mss_cmd_t cmd;
  mss_pkg::mss_sts_t sts;

  // Sequencer for one item at a time.
  mss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Store, stack limits, shifter and result register.
  mss_dpath #(
    .NUM_STACKS  (NUM_STACKS),
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: rtl/mss_ctrl.sv
`timescale 1ns / 1ps
`include "multi_stack_shared_store_defines.svh"

module mss_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  mss_pkg::mss_sts_t sts,
  output mss_pkg::mss_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_GET_S,
    S_GET_S1,
    S_DECIDE,
    S_POP_WAIT,
    S_SCAN_R,
    S_SCAN_L,
    S_SHIFT,
    S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   busy_r;

  // Next state and the commands for the current cycle.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_GET_S;
        end
      end
      S_GET_S: begin
        cmd.rd_sel = mss_pkg::RD_S;
        cmd.cap_s  = 1'b1;
        state_nxt  = S_GET_S1;
      end
      S_GET_S1: begin
        cmd.rd_sel = mss_pkg::RD_S1;
        cmd.cap_s1 = 1'b1;
        state_nxt  = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.bad_index) begin
          cmd.respond     = 1'b1;
          cmd.resp_status = sts.is_pop ? mss_pkg::ST_EMPTY : mss_pkg::ST_FULL;
          cmd.resp_size   = mss_pkg::SZ_ZERO;
          state_nxt       = S_IDLE;
        end else if (sts.is_pop) begin
          if (sts.empty) begin
            cmd.respond     = 1'b1;
            cmd.resp_status = mss_pkg::ST_EMPTY;
            cmd.resp_size   = mss_pkg::SZ_SAME;
            state_nxt       = S_IDLE;
          end else begin
            cmd.pop_read = 1'b1;
            state_nxt    = S_POP_WAIT;
          end
        end else if (sts.room) begin
          state_nxt = S_PUSH;
        end else if (!sts.s_last) begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN_R;
        end else if (!sts.s_zero) begin
          cmd.scan_init = 1'b1;
          cmd.left      = 1'b1;
          state_nxt     = S_SCAN_L;
        end else begin
          cmd.respond     = 1'b1;
          cmd.resp_status = mss_pkg::ST_FULL;
          cmd.resp_size   = mss_pkg::SZ_SAME;
          state_nxt       = S_IDLE;
        end
      end
      S_POP_WAIT: begin
        cmd.respond     = 1'b1;
        cmd.resp_status = mss_pkg::ST_DONE;
        cmd.resp_size   = mss_pkg::SZ_DEC;
        cmd.resp_pop    = 1'b1;
        cmd.pop_commit  = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_SCAN_R: begin
        cmd.rd_sel = mss_pkg::RD_P;
        if (sts.p_free) begin
          cmd.hit   = 1'b1;
          state_nxt = S_SHIFT;
        end else if (sts.p_last) begin
          if (sts.s_zero) begin
            cmd.respond     = 1'b1;
            cmd.resp_status = mss_pkg::ST_FULL;
            cmd.resp_size   = mss_pkg::SZ_SAME;
            state_nxt       = S_IDLE;
          end else begin
            cmd.scan_init = 1'b1;
            cmd.left      = 1'b1;
            state_nxt     = S_SCAN_L;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SCAN_L: begin
        cmd.rd_sel = mss_pkg::RD_P;
        cmd.left   = 1'b1;
        if (sts.p_free) begin
          cmd.hit   = 1'b1;
          state_nxt = S_SHIFT;
        end else if (sts.p_zero) begin
          cmd.respond     = 1'b1;
          cmd.resp_status = mss_pkg::ST_FULL;
          cmd.resp_size   = mss_pkg::SZ_SAME;
          state_nxt       = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SHIFT: begin
        if (!sts.shift_busy) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.rd_sel      = mss_pkg::RD_S;
        cmd.push_write  = 1'b1;
        cmd.respond     = 1'b1;
        cmd.resp_status = mss_pkg::ST_DONE;
        cmd.resp_size   = mss_pkg::SZ_INC;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register and the registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

  // The shifter must be quiet whenever no item is in progress.
  `MSS_ASSERT_IMPLY(a_idle_no_shift, clk, rst_n, state_r == S_IDLE, !sts.shift_busy, "shift active while idle")
  // A finished shift always leads straight into the push.
  `MSS_ASSERT_NEXT(a_shift_to_push, clk, rst_n, (state_r == S_SHIFT) && !sts.shift_busy, state_r == S_PUSH, "shift did not end in a push")

endmodule

// File: rtl/mss_dpath.sv
`timescale 1ns / 1ps
`include "multi_stack_shared_store_defines.svh"

module mss_dpath #(
  parameter int NUM_STACKS  = 13,
  parameter int CAPACITY    = 52,
  parameter int ENTRY_WIDTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mss_pkg::mss_in_t  in_item,
  input  mss_pkg::mss_cmd_t cmd,
  output mss_pkg::mss_sts_t sts,
  output logic              out_valid,
  output mss_pkg::mss_out_t out_item
);

  // Address width holds 0..CAPACITY, slot width indexes the store.
  localparam int AW  = $clog2(CAPACITY + 1);
  localparam int SLW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SW  = $clog2(NUM_STACKS + 1);
  localparam int IW  = (SW > 4) ? SW : 4;

  mss_pkg::mss_in_t       item_r;
  logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rdata_r;

  logic [AW-1:0] tops_r  [NUM_STACKS];
  logic [AW-1:0] bases_r [NUM_STACKS + 1];

  logic [AW-1:0] top_s_r;
  logic [AW-1:0] base_s_r;
  logic [AW-1:0] base_s1_r;
  logic [SW-1:0] p_r;

  logic [AW-1:0]  src_r, src_nxt;
  logic [AW-1:0]  cnt_r, cnt_nxt;
  logic           shl_r, shl_nxt;
  logic           wr_pend_r, wr_pend_nxt;
  logic [SLW-1:0] wr_slot_r, wr_slot_nxt;

  logic              out_valid_r;
  mss_pkg::mss_out_t out_r;

  logic [IW-1:0]  idx_ext;
  logic           bad;
  logic [SW-1:0]  s;
  logic [SW-1:0]  t_idx, b_idx;
  logic [AW-1:0]  t_rd, b_rd;
  logic [AW-1:0]  size_s, size_v;
  logic [SLW-1:0] rd_slot, mem_wslot;
  logic           mem_we;
  logic [ENTRY_WIDTH-1:0] mem_wdata;

  // Item register, taken when the controller accepts a new item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
  end

  assign idx_ext = IW'(item_r.stack_index);
  assign bad     = (idx_ext >= IW'(NUM_STACKS));
  assign s       = SW'(idx_ext);

  // Single read port on the tops and on the bases, steered by the controller.
  always_comb begin
    t_idx = s;
    b_idx = s;
    case (cmd.rd_sel)
      mss_pkg::RD_S: begin
        t_idx = s;
        b_idx = s;
      end
      mss_pkg::RD_S1: begin
        b_idx = s + SW'(1);
      end
      mss_pkg::RD_P: begin
        t_idx = p_r;
        b_idx = p_r + SW'(1);
      end
      default: begin
        t_idx = s;
      end
    endcase
    t_rd = '0;
    b_rd = '0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      if (t_idx == SW'(i)) t_rd = tops_r[i];
    end
    for (int i = 0; i <= NUM_STACKS; i++) begin
      if (b_idx == SW'(i)) b_rd = bases_r[i];
    end
  end

  // Stack tops: reset to an even split, moved by pushes, pops and repacking.
  for (genvar g = 0; g < NUM_STACKS; g++) begin : g_top
    localparam logic [AW-1:0] RstVal = AW'((g * CAPACITY) / NUM_STACKS);
    logic          in_rng;
    logic [AW-1:0] top_nxt;

    assign in_rng = cmd.left ? ((SW'(g) > p_r) && (SW'(g) <= s))
                             : ((SW'(g) > s) && (SW'(g) <= p_r));

    always_comb begin
      top_nxt = tops_r[g];
      if (cmd.hit && in_rng) begin
        top_nxt = cmd.left ? tops_r[g] - AW'(1) : tops_r[g] + AW'(1);
      end else if (cmd.push_write && (s == SW'(g))) begin
        top_nxt = tops_r[g] + AW'(1);
      end else if (cmd.pop_commit && (s == SW'(g))) begin
        top_nxt = tops_r[g] - AW'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tops_r[g] <= RstVal;
      end else begin
        tops_r[g] <= top_nxt;
      end
    end
  end

  // Stack bases: only repacking moves them; the outer two never change.
  for (genvar g = 0; g <= NUM_STACKS; g++) begin : g_base
    localparam logic [AW-1:0] RstVal = AW'((g * CAPACITY) / NUM_STACKS);
    logic          in_rng;
    logic [AW-1:0] base_nxt;

    assign in_rng = cmd.left ? ((SW'(g) > p_r) && (SW'(g) <= s))
                             : ((SW'(g) > s) && (SW'(g) <= p_r));

    always_comb begin
      base_nxt = bases_r[g];
      if (cmd.hit && in_rng) begin
        base_nxt = cmd.left ? bases_r[g] - AW'(1) : bases_r[g] + AW'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        bases_r[g] <= RstVal;
      end else begin
        bases_r[g] <= base_nxt;
      end
    end
  end

  // Captured limits of the addressed stack and the scan pointer.
  always_ff @(posedge clk) begin
    if (cmd.cap_s) begin
      top_s_r  <= t_rd;
      base_s_r <= b_rd;
    end
    if (cmd.cap_s1) begin
      base_s1_r <= b_rd;
    end
    if (cmd.scan_init) begin
      p_r <= cmd.left ? s - SW'(1) : s + SW'(1);
    end else if (cmd.scan_step) begin
      p_r <= cmd.left ? p_r - SW'(1) : p_r + SW'(1);
    end
  end

  // Shifter: one entry read per cycle; the registered read data is written one slot over.
  always_comb begin
    src_nxt     = src_r;
    cnt_nxt     = cnt_r;
    shl_nxt     = shl_r;
    wr_pend_nxt = 1'b0;
    wr_slot_nxt = wr_slot_r;
    if (cmd.hit) begin
      shl_nxt = cmd.left;
      if (cmd.left) begin
        src_nxt = b_rd + AW'(1);
        cnt_nxt = top_s_r - b_rd;
      end else begin
        src_nxt = t_rd;
        cnt_nxt = t_rd - base_s1_r;
      end
    end else if (cnt_r != '0) begin
      src_nxt     = shl_r ? src_r + AW'(1) : src_r - AW'(1);
      cnt_nxt     = cnt_r - AW'(1);
      wr_pend_nxt = 1'b1;
      wr_slot_nxt = shl_r ? SLW'(src_r - AW'(2)) : SLW'(src_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
    src_r     <= src_nxt;
    shl_r     <= shl_nxt;
    wr_slot_r <= wr_slot_nxt;
  end

  // Entry store: one write port, one registered read port.
  assign rd_slot   = cmd.pop_read ? SLW'(top_s_r - AW'(1)) : SLW'(src_r - AW'(1));
  assign mem_we    = wr_pend_r | cmd.push_write;
  assign mem_wslot = wr_pend_r ? wr_slot_r : SLW'(t_rd);
  assign mem_wdata = wr_pend_r ? rdata_r : ENTRY_WIDTH'(item_r.push_data);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wslot] <= mem_wdata;
    end
    rdata_r <= mem[rd_slot];
  end

  // Status towards the controller.
  assign sts.bad_index  = bad;
  assign sts.is_pop     = (item_r.action == mss_pkg::ACT_POP);
  assign sts.empty      = (top_s_r == base_s_r);
  assign sts.room       = (top_s_r < base_s1_r);
  assign sts.p_free     = (t_rd < b_rd);
  assign sts.p_last     = (p_r == SW'(NUM_STACKS - 1));
  assign sts.p_zero     = (p_r == '0);
  assign sts.s_last     = (s == SW'(NUM_STACKS - 1));
  assign sts.s_zero     = (s == '0);
  assign sts.shift_busy = (cnt_r != '0) | wr_pend_r;

  // Result register: one strobe cycle per transfer.
  assign size_s = top_s_r - base_s_r;

  always_comb begin
    case (cmd.resp_size)
      mss_pkg::SZ_ZERO: size_v = '0;
      mss_pkg::SZ_SAME: size_v = size_s;
      mss_pkg::SZ_DEC:  size_v = size_s - AW'(1);
      mss_pkg::SZ_INC:  size_v = size_s + AW'(1);
      default:          size_v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
    end
    if (cmd.respond) begin
      out_r.pop_data   <= cmd.resp_pop ? 8'(rdata_r) : 8'd0;
      out_r.status     <= cmd.resp_status;
      out_r.stack_size <= 6'(size_v);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A shift write and the push write never compete for the store port.
  `MSS_ASSERT_NEVER(a_no_dual_write, clk, rst_n, wr_pend_r && cmd.push_write, "two store writes in one cycle")
  // A push always lands inside the store.
  `MSS_ASSERT_IMPLY(a_push_in_store, clk, rst_n, cmd.push_write, t_rd < AW'(CAPACITY), "push beyond the store")
  // Results are never shown in two consecutive cycles.
  `MSS_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid_r, !out_valid_r, "result strobe held high")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int NUM_STACKS  = 13;
  localparam int CAPACITY    = 52;
  localparam int ENTRY_WIDTH = 8;
  // Longest quiet stretch of a correct run is a full repack plus a sender gap;
  // the limit allows many times that.
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_REPORTS = 100;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  mss_pkg::mss_in_t  in_item;
  logic              out_valid;
  mss_pkg::mss_out_t out_item;

  // Shadow copy of the shared store, its bases and its tops.
  logic [ENTRY_WIDTH-1:0] shadow_store [1:CAPACITY];
  int                     stack_base   [0:NUM_STACKS];
  int                     stack_top    [0:NUM_STACKS-1];

  mss_pkg::mss_out_t expected_results [$];

  bit idle_enable;
  int idle_pct;
  int mismatch_count;
  int quiet_cycles;
  int push_count;
  int pop_count;
  int right_repacks;
  int left_repacks;
  int empty_pops;
  int full_pushes;

  multi_stack_shared_store #(
    .NUM_STACKS  (NUM_STACKS),
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Free-running clock with a 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Print one line per mismatch, up to a cap, and count every one.
  task automatic report_mismatch(input string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Split the store evenly and empty every stack, as after reset.
  task automatic reset_shadow();
    for (int i = 0; i <= NUM_STACKS; i++) begin
      stack_base[i] = (i * CAPACITY) / NUM_STACKS;
    end
    for (int i = 0; i < NUM_STACKS; i++) begin
      stack_top[i] = stack_base[i];
    end
    for (int a = 1; a <= CAPACITY; a++) begin
      shadow_store[a] = '0;
    end
  endtask

  function automatic int stored_total();
    int total;
    total = 0;
    for (int i = 0; i < NUM_STACKS; i++) begin
      total += stack_top[i] - stack_base[i];
    end
    return total;
  endfunction

  // Open one slot above the top of stack s by moving the stacks in between.
  task automatic repack_for_push(input int s, output bit found);
    int j;
    found = 1'b0;
    // Nearest stack to the right with free room: shift entries up one slot.
    for (j = s + 1; j < NUM_STACKS && !found; j++) begin
      if (stack_top[j] < stack_base[j+1]) begin
        for (int a = stack_top[j]; a > stack_base[s+1]; a--) begin
          shadow_store[a+1] = shadow_store[a];
        end
        for (int k = s + 1; k <= j; k++) begin
          stack_base[k]++;
          stack_top[k]++;
        end
        found = 1'b1;
        right_repacks++;
      end
    end
    // Otherwise the nearest stack to the left: shift entries down one slot.
    for (j = s; j > 0 && !found; j--) begin
      if (stack_top[j-1] < stack_base[j]) begin
        for (int a = stack_base[j]; a < stack_top[s]; a++) begin
          shadow_store[a] = shadow_store[a+1];
        end
        for (int k = j; k <= s; k++) begin
          stack_base[k]--;
          stack_top[k]--;
        end
        found = 1'b1;
        left_repacks++;
      end
    end
  endtask

  // Work out the result of one operation and update the shadow state.
  task automatic predict_stack_op(input mss_pkg::mss_in_t op,
                                  output mss_pkg::mss_out_t res);
    int s;
    bit room;
    res = '0;
    res.status = mss_pkg::ST_DONE;
    if (op.action == mss_pkg::ACT_POP) begin
      pop_count++;
    end else begin
      push_count++;
    end
    if (op.stack_index >= NUM_STACKS) begin
      // A stack beyond the last one is always empty and never has room.
      res.status = (op.action == mss_pkg::ACT_POP) ? mss_pkg::ST_EMPTY : mss_pkg::ST_FULL;
    end else begin
      s = op.stack_index;
      if (op.action == mss_pkg::ACT_POP) begin
        if (stack_top[s] == stack_base[s]) begin
          res.status = mss_pkg::ST_EMPTY;
        end else begin
          res.pop_data = shadow_store[stack_top[s]];
          stack_top[s]--;
        end
      end else begin
        room = 1'b1;
        if (stack_top[s] >= stack_base[s+1]) begin
          repack_for_push(s, room);
        end
        if (room) begin
          stack_top[s]++;
          shadow_store[stack_top[s]] = op.push_data;
        end else begin
          res.status = mss_pkg::ST_FULL;
        end
      end
      res.stack_size = 6'(stack_top[s] - stack_base[s]);
    end
    if (res.status == mss_pkg::ST_EMPTY) begin
      empty_pops++;
    end
    if (res.status == mss_pkg::ST_FULL) begin
      full_pushes++;
    end
  endtask

  // Let the sender go quiet for a random burst now and then.
  task automatic sender_gap();
    if (idle_enable && $urandom_range(0, 99) < idle_pct) begin
      start   = 1'b0;
      in_item = mss_pkg::mss_in_t'($urandom_range(0, 8191));
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
  endtask

  // Offer one operation from a falling edge and hold it until it transfers.
  task automatic issue_op(input mss_pkg::mss_in_t op);
    mss_pkg::mss_out_t res;
    sender_gap();
    start   = 1'b1;
    in_item = op;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_stack_op(op, res);
    expected_results.push_back(res);
    @(negedge clk);
  endtask

  function automatic mss_pkg::mss_in_t make_op(input mss_pkg::mss_action_t act,
                                               input int idx, input int data);
    mss_pkg::mss_in_t op;
    op.action      = act;
    op.stack_index = 4'(idx);
    op.push_data   = 8'(data);
    return op;
  endfunction

  // Random operation: mostly legal stacks, a hot stack to force repacking.
  function automatic mss_pkg::mss_in_t random_op(input int push_pct, input int hot,
                                                 input int hot_pct);
    int idx;
    mss_pkg::mss_action_t act;
    act = ($urandom_range(0, 99) < push_pct) ? mss_pkg::ACT_PUSH : mss_pkg::ACT_POP;
    if ($urandom_range(0, 99) < 3) begin
      idx = $urandom_range(NUM_STACKS, 15);
    end else if ($urandom_range(0, 99) < hot_pct) begin
      idx = hot;
    end else begin
      idx = $urandom_range(0, NUM_STACKS - 1);
    end
    return make_op(act, idx, $urandom_range(0, 255));
  endfunction

  // Hold the sender off until every expected result has come back.
  task automatic wait_for_results();
    start = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Edge values, bad indexes, empty pops and a repack in each direction.
  task automatic test_directed();
    issue_op(make_op(mss_pkg::ACT_POP, 0, 8'h00));
    issue_op(make_op(mss_pkg::ACT_POP, NUM_STACKS - 1, 8'hff));
    issue_op(make_op(mss_pkg::ACT_POP, NUM_STACKS, 8'h5a));
    issue_op(make_op(mss_pkg::ACT_POP, 15, 8'ha5));
    issue_op(make_op(mss_pkg::ACT_PUSH, 14, 8'hff));
    issue_op(make_op(mss_pkg::ACT_PUSH, 0, 8'h00));
    issue_op(make_op(mss_pkg::ACT_PUSH, 0, 8'hff));
    issue_op(make_op(mss_pkg::ACT_POP, 0, 8'h00));
    issue_op(make_op(mss_pkg::ACT_POP, 0, 8'h00));
    // The last stack has nothing to its right, so the fifth push shifts left.
    for (int i = 0; i < 5; i++) begin
      issue_op(make_op(mss_pkg::ACT_PUSH, NUM_STACKS - 1, 8'h10 + i));
    end
    issue_op(make_op(mss_pkg::ACT_POP, NUM_STACKS - 1, 8'h00));
    // The first stack overflows into its right neighbour.
    for (int i = 0; i < 5; i++) begin
      issue_op(make_op(mss_pkg::ACT_PUSH, 0, 8'he0 + i));
    end
    issue_op(make_op(mss_pkg::ACT_POP, 0, 8'h00));
    issue_op(make_op(mss_pkg::ACT_POP, 1, 8'h00));
    wait_for_results();
  endtask

  // Fill the whole store, push into it while full, then empty it again.
  task automatic test_fill_and_drain();
    int s;
    while (stored_total() < CAPACITY) begin
      issue_op(make_op(mss_pkg::ACT_PUSH, $urandom_range(0, NUM_STACKS - 1),
                       $urandom_range(0, 255)));
    end
    for (int i = 0; i < 4; i++) begin
      issue_op(make_op(mss_pkg::ACT_PUSH, $urandom_range(0, 15), $urandom_range(0, 255)));
    end
    while (stored_total() > 0) begin
      s = $urandom_range(0, NUM_STACKS - 1);
      // Steer most pops to a stack that still holds entries.
      if ($urandom_range(0, 99) < 80) begin
        for (int i = 0; i < NUM_STACKS && stack_top[s] == stack_base[s]; i++) begin
          s = (s + 1) % NUM_STACKS;
        end
      end
      issue_op(make_op(mss_pkg::ACT_POP, s, $urandom_range(0, 255)));
    end
  endtask

  // A run of random operations with a given push share and hot stack.
  task automatic test_random_traffic(input int count, input int push_pct);
    int hot;
    hot = $urandom_range(0, NUM_STACKS - 1);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        hot = $urandom_range(0, NUM_STACKS - 1);
      end
      issue_op(random_op(push_pct, hot, 40));
    end
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    mss_pkg::mss_out_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: %p", out_item));
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.pop_data !== exp_res.pop_data) begin
          report_mismatch($sformatf("pop_data %0h, wanted %0h",
                                    out_item.pop_data, exp_res.pop_data));
        end
        if (out_item.status !== exp_res.status) begin
          report_mismatch($sformatf("status %0d, wanted %0d",
                                    out_item.status, exp_res.status));
        end
        if (out_item.stack_size !== exp_res.stack_size) begin
          report_mismatch($sformatf("stack_size %0d, wanted %0d",
                                    out_item.stack_size, exp_res.stack_size));
        end
      end
    end
  end

  // End the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Reset once, then run the tests in turn.
  initial begin
    start          = 1'b0;
    in_item        = '0;
    rst_n          = 1'b0;
    idle_enable    = 1'b1;
    idle_pct       = 20;
    mismatch_count = 0;
    quiet_cycles   = 0;
    push_count     = 0;
    pop_count      = 0;
    right_repacks  = 0;
    left_repacks   = 0;
    empty_pops     = 0;
    full_pushes    = 0;
    reset_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_fill_and_drain();
    idle_pct = 30;
    test_random_traffic(300, 70);
    wait_for_results();
    idle_pct = 10;
    test_random_traffic(250, 35);
    idle_pct = 0;
    test_random_traffic(100, 75);
    // Final stretch runs back to back.
    idle_enable = 1'b0;
    test_random_traffic(150, 60);

    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end

    $display("Covered %0d pushes and %0d pops, with %0d right and %0d left repacks.",
             push_count, pop_count, right_repacks, left_repacks);
    $display("Flagged: %0d pops from empty stacks, %0d pushes refused for lack of room.",
             empty_pops, full_pushes);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
